FILE: design/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 x86_128 block.
// Used by mm3_ctrl and murmur3_x86_128_hash_top; no dependencies.
`timescale 1ns / 1ps

package mm3_pkg;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BLK_MUL1,
        ST_BLK_MUL2,
        ST_BLK_MIX,
        ST_BLK_ADD,
        ST_TAIL_MUL1,
        ST_TAIL_MUL2,
        ST_TAIL_XOR,
        ST_FIN_LEN,
        ST_FIN_SUM,
        ST_FIN_SPREAD,
        ST_FMIX_MUL1,
        ST_FMIX_MUL2,
        ST_FMIX_XOR,
        ST_OUT_SUM,
        ST_OUT_WRITE
    } state_t;

    // Start request from the input side
    typedef struct packed {
        logic blk;   // block round needed
        logic tail;  // tail mixing needed
        logic last;  // final item of the message
    } go_t;

    // Sequencer view handed to the datapath
    typedef struct packed {
        state_t     state;
        logic [1:0] lane;
    } ctrl_t;

    localparam logic [31:0] FMIX_C1   = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2   = 32'hc2b2ae35;
    localparam logic [2:0]  FULL_WORD = 3'd4;

    // First scramble constant per lane
    function automatic logic [31:0] scr_c1(input logic [1:0] lane);
        logic [31:0] c;
        case (lane)
            2'd0:    c = 32'h239b961b;
            2'd1:    c = 32'hab0e9789;
            2'd2:    c = 32'h38b34ae5;
            default: c = 32'ha1e38b93;
        endcase
        return c;
    endfunction

    // Second scramble constant per lane
    function automatic logic [31:0] scr_c2(input logic [1:0] lane);
        logic [31:0] c;
        case (lane)
            2'd0:    c = 32'hab0e9789;
            2'd1:    c = 32'h38b34ae5;
            2'd2:    c = 32'ha1e38b93;
            default: c = 32'h239b961b;
        endcase
        return c;
    endfunction

    // Scramble rotation: 15, 16, 17, 18
    function automatic logic [31:0] scr_rotl(input logic [1:0] lane, input logic [31:0] x);
        logic [31:0] r;
        case (lane)
            2'd0:    r = {x[16:0], x[31:17]};
            2'd1:    r = {x[15:0], x[31:16]};
            2'd2:    r = {x[14:0], x[31:15]};
            default: r = {x[13:0], x[31:14]};
        endcase
        return r;
    endfunction

    // Block-round lane rotation: 19, 17, 15, 13
    function automatic logic [31:0] blk_rotl(input logic [1:0] lane, input logic [31:0] x);
        logic [31:0] r;
        case (lane)
            2'd0:    r = {x[12:0], x[31:13]};
            2'd1:    r = {x[14:0], x[31:15]};
            2'd2:    r = {x[16:0], x[31:17]};
            default: r = {x[18:0], x[31:19]};
        endcase
        return r;
    endfunction

    // Block-round lane offset
    function automatic logic [31:0] blk_add(input logic [1:0] lane);
        logic [31:0] c;
        case (lane)
            2'd0:    c = 32'h561ccd1b;
            2'd1:    c = 32'h0bcaa747;
            2'd2:    c = 32'h96cd1c35;
            default: c = 32'h32ac3b17;
        endcase
        return c;
    endfunction

    // Byte count clamped to a full word
    function automatic logic [2:0] cnt_sat(input logic [2:0] cnt);
        return (cnt > FULL_WORD) ? FULL_WORD : cnt;
    endfunction

    // Zero the bytes at and above the (clamped) count
    function automatic logic [31:0] byte_mask(input logic [31:0] w, input logic [2:0] cnt);
        logic [31:0] r;
        case (cnt)
            3'd0:    r = 32'd0;
            3'd1:    r = {24'd0, w[7:0]};
            3'd2:    r = {16'd0, w[15:0]};
            3'd3:    r = {8'd0, w[23:0]};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

FILE: design/mm3_mul.sv
// Shared 32x32 multiplier, low 32 bits of the product, registered.
// Depends on nothing; used by murmur3_x86_128_hash_top.
`timescale 1ns / 1ps

module mm3_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] product
);

    logic [63:0] full_prod;
    logic [31:0] product_reg;

    assign full_prod = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= full_prod[31:0];
        end
    end

    assign product = product_reg;

endmodule

FILE: design/mm3_ctrl.sv
// Sequencer for the MurmurHash3 block: state and lane counter.
// Depends on mm3_pkg; drives the datapath in murmur3_x86_128_hash_top.
`timescale 1ns / 1ps

module mm3_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  mm3_pkg::go_t   go,
    input  logic           out_free,
    output mm3_pkg::ctrl_t ctrl
);

    mm3_pkg::state_t state_reg, state_next;
    logic [1:0]      lane_reg, lane_next;
    logic            last_reg, last_next;
    logic            lane_end;

    assign lane_end = (lane_reg == 2'd3);

    // next state
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        last_next  = last_reg;
        unique case (state_reg)
            mm3_pkg::ST_IDLE:
            begin
                if (go.blk)
                begin
                    state_next = mm3_pkg::ST_BLK_MUL1;
                    last_next  = go.last;
                end
                else if (go.tail)
                begin
                    state_next = mm3_pkg::ST_TAIL_MUL1;
                end
            end
            mm3_pkg::ST_BLK_MUL1:  state_next = mm3_pkg::ST_BLK_MUL2;
            mm3_pkg::ST_BLK_MUL2:  state_next = mm3_pkg::ST_BLK_MIX;
            mm3_pkg::ST_BLK_MIX:   state_next = mm3_pkg::ST_BLK_ADD;
            mm3_pkg::ST_BLK_ADD:
            begin
                // lane counter wraps back to zero after lane 3
                lane_next = lane_reg + 2'd1;
                if (!lane_end)
                    state_next = mm3_pkg::ST_BLK_MUL1;
                else if (last_reg)
                    state_next = mm3_pkg::ST_FIN_LEN;
                else
                    state_next = mm3_pkg::ST_IDLE;
            end
            mm3_pkg::ST_TAIL_MUL1: state_next = mm3_pkg::ST_TAIL_MUL2;
            mm3_pkg::ST_TAIL_MUL2: state_next = mm3_pkg::ST_TAIL_XOR;
            mm3_pkg::ST_TAIL_XOR:
            begin
                lane_next  = lane_reg + 2'd1;
                state_next = lane_end ? mm3_pkg::ST_FIN_LEN : mm3_pkg::ST_TAIL_MUL1;
            end
            mm3_pkg::ST_FIN_LEN:    state_next = mm3_pkg::ST_FIN_SUM;
            mm3_pkg::ST_FIN_SUM:    state_next = mm3_pkg::ST_FIN_SPREAD;
            mm3_pkg::ST_FIN_SPREAD: state_next = mm3_pkg::ST_FMIX_MUL1;
            mm3_pkg::ST_FMIX_MUL1:  state_next = mm3_pkg::ST_FMIX_MUL2;
            mm3_pkg::ST_FMIX_MUL2:  state_next = mm3_pkg::ST_FMIX_XOR;
            mm3_pkg::ST_FMIX_XOR:
            begin
                lane_next  = lane_reg + 2'd1;
                state_next = lane_end ? mm3_pkg::ST_OUT_SUM : mm3_pkg::ST_FMIX_MUL1;
            end
            mm3_pkg::ST_OUT_SUM:    state_next = mm3_pkg::ST_OUT_WRITE;
            mm3_pkg::ST_OUT_WRITE:
            begin
                if (out_free)
                begin
                    state_next = mm3_pkg::ST_IDLE;
                    last_next  = 1'b0;
                end
            end
            default:                state_next = mm3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm3_pkg::ST_IDLE;
            lane_reg  <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            last_reg  <= last_next;
        end
    end

    // outputs
    always_comb
    begin
        ctrl.state = state_reg;
        ctrl.lane  = lane_reg;
    end

endmodule

FILE: design/murmur3_x86_128_hash_top.sv
// Top level of the streaming MurmurHash3 x86_128 hasher (low 64 bits out).
// Depends on mm3_pkg, mm3_mul and mm3_ctrl.
`timescale 1ns / 1ps

// Channel   Signals                                          Direction
// input     in_valid, in_ready, data_word, byte_count, last  in (item per word)
// output    out_valid, out_ready, hash_value                 out (item per message)
// config    cfg_valid, cfg_ready, seed                       in (write only)
//
// A held word is taken while idle; the fourth word of a block starts a block round
// (4 lanes x 4 steps on the shared multiplier). A last item starts tail mixing
// (a block round for a full block), then length xor, cross-adds and fmix32.
// Reset clears control only; lanes are loaded from the seed at message start.
// out_ready low holds the finished hash in the output register; held words may
// still be accepted, and a next last item waits at its final write.

module murmur3_x86_128_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    // result
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value,
    // seed register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] seed
);

    mm3_pkg::ctrl_t ctrl;
    mm3_pkg::go_t   go;

    logic        in_accept;
    logic        out_free;
    logic [2:0]  cnt_eff;
    logic [31:0] word_eff;

    // control state
    logic [31:0] seed_reg;
    logic        active_reg;
    logic [1:0]  pos_reg;
    logic [31:0] len_reg;
    logic        out_valid_reg;

    // payload state
    logic [31:0] lane_hash_reg [4];
    logic [31:0] lane_hash_next [4];
    logic [31:0] pend_reg [3];
    logic [31:0] word_reg;
    logic [1:0]  kpos_reg;
    logic [31:0] t_reg, t_next;
    logic [63:0] hash_reg;

    // shared multiplier
    logic        mul_en;
    logic [31:0] mul_a, mul_b, prod;

    logic [1:0]  lane, lane_nx;
    logic [31:0] lane_cur, k_sel, fmix_in, fmix_mid;
    logic [31:0] sum4;

    assign lane    = ctrl.lane;
    assign lane_nx = ctrl.lane + 2'd1;

    assign in_ready  = (ctrl.state == mm3_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;

    // last word is clipped to its byte count; other words count as full
    assign cnt_eff  = last ? mm3_pkg::cnt_sat(byte_count) : mm3_pkg::FULL_WORD;
    assign word_eff = mm3_pkg::byte_mask(data_word, cnt_eff);

    // block round when the fourth full word arrives, tail mixing on any other last
    always_comb
    begin
        go.blk  = in_accept && (pos_reg == 2'd3) && (cnt_eff == mm3_pkg::FULL_WORD);
        go.tail = in_accept && last && !go.blk;
        go.last = last;
    end

    mm3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // key word for the current lane: held words, then this word, then zeros
    always_comb
    begin
        k_sel = 32'd0;
        if (lane == kpos_reg)
            k_sel = word_reg;
        else if (lane < kpos_reg)
        begin
            case (lane)
                2'd0:    k_sel = pend_reg[0];
                2'd1:    k_sel = pend_reg[1];
                default: k_sel = pend_reg[2];
            endcase
        end
    end

    assign lane_cur = lane_hash_reg[lane];
    assign fmix_in  = lane_cur ^ {16'd0, lane_cur[31:16]};
    assign fmix_mid = prod ^ {13'd0, prod[31:13]};
    assign sum4     = (lane_hash_reg[0] + lane_hash_reg[1])
                    + (lane_hash_reg[2] + lane_hash_reg[3]);

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        case (ctrl.state)
            mm3_pkg::ST_BLK_MUL1, mm3_pkg::ST_TAIL_MUL1:
            begin
                mul_a = k_sel;
                mul_b = mm3_pkg::scr_c1(lane);
            end
            mm3_pkg::ST_BLK_MUL2, mm3_pkg::ST_TAIL_MUL2:
            begin
                mul_a = mm3_pkg::scr_rotl(lane, prod);
                mul_b = mm3_pkg::scr_c2(lane);
            end
            mm3_pkg::ST_FMIX_MUL1:
            begin
                mul_a = fmix_in;
                mul_b = mm3_pkg::FMIX_C1;
            end
            mm3_pkg::ST_FMIX_MUL2:
            begin
                mul_a = fmix_mid;
                mul_b = mm3_pkg::FMIX_C2;
            end
            default: mul_en = 1'b0;
        endcase
    end

    mm3_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    // lane datapath
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            lane_hash_next[j] = lane_hash_reg[j];
        t_next = t_reg;
        case (ctrl.state)
            mm3_pkg::ST_IDLE:
            begin
                // fresh message: lanes start from the seed
                if (in_accept && !active_reg)
                begin
                    for (int j = 0; j < 4; j++)
                        lane_hash_next[j] = seed_reg;
                end
            end
            mm3_pkg::ST_BLK_MIX:
                t_next = mm3_pkg::blk_rotl(lane, lane_cur ^ prod) + lane_hash_reg[lane_nx];
            mm3_pkg::ST_BLK_ADD:
                // h * 5 + offset
                lane_hash_next[lane] = t_reg + {t_reg[29:0], 2'b00} + mm3_pkg::blk_add(lane);
            mm3_pkg::ST_TAIL_XOR:
                lane_hash_next[lane] = lane_cur ^ prod;
            mm3_pkg::ST_FIN_LEN:
            begin
                for (int j = 0; j < 4; j++)
                    lane_hash_next[j] = lane_hash_reg[j] ^ len_reg;
            end
            mm3_pkg::ST_FIN_SUM, mm3_pkg::ST_OUT_SUM:
                lane_hash_next[0] = sum4;
            mm3_pkg::ST_FIN_SPREAD:
            begin
                for (int j = 1; j < 4; j++)
                    lane_hash_next[j] = lane_hash_reg[j] + lane_hash_reg[0];
            end
            mm3_pkg::ST_FMIX_XOR:
                lane_hash_next[lane] = prod ^ {16'd0, prod[31:16]};
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
            lane_hash_reg[j] <= lane_hash_next[j];
        t_reg <= t_next;
        if (in_accept)
        begin
            word_reg <= word_eff;
            kpos_reg <= pos_reg;
            if (!last && pos_reg != 2'd3)
                pend_reg[pos_reg] <= data_word;
        end
        if (ctrl.state == mm3_pkg::ST_OUT_WRITE && out_free)
            hash_reg <= {lane_hash_reg[1] + lane_hash_reg[0], lane_hash_reg[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            active_reg    <= 1'b0;
            pos_reg       <= 2'd0;
            len_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_reg <= seed;
            if (ctrl.state == mm3_pkg::ST_OUT_WRITE && out_free)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= 1'b0;
                pos_reg       <= 2'd0;
                len_reg       <= 32'd0;
            end
            else
            begin
                if (out_ready)
                    out_valid_reg <= 1'b0;
                if (in_accept)
                begin
                    active_reg <= 1'b1;
                    pos_reg    <= pos_reg + 2'd1;
                    len_reg    <= len_reg + {29'd0, cnt_eff};
                end
            end
        end
    end

endmodule

FILE: design/mm3_checker.sv
// Port-level checks for murmur3_x86_128_hash_top, attached with bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module mm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_value
);

    // a last word always starts the multi-cycle finish
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input ready right after a last item");

    // results appear only out of the finishing sequence
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input side was idle");

    // no result can rise in the cycle right after any accept
    a_no_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result right after an accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value))
        else $error("stalled result changed");

endmodule

bind murmur3_x86_128_hash_top mm3_checker u_mm3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
);

FILE: tb/sv/hash_sb_pkg.sv
// Scoreboard for the streaming MurmurHash3 x86_128 hasher: word-level predictor
// and queue of expected hash items. Depends on mm3_pkg for the fmix32 constants.
`timescale 1ns / 1ps

package hash_sb_pkg;

    class hash_scoreboard;
        logic [31:0] seed_val;
        logic [31:0] lane[4];
        logic [31:0] held[3];
        int unsigned slot;
        logic [31:0] msg_bytes;
        bit          in_msg;
        logic [31:0] scr_c[4];
        logic [31:0] blk_c[4];
        logic [63:0] hash_q[$];
        int unsigned fail_cnt;

        function new();
            scr_c = '{32'h239b961b, 32'hab0e9789, 32'h38b34ae5, 32'ha1e38b93};
            blk_c = '{32'h561ccd1b, 32'h0bcaa747, 32'h96cd1c35, 32'h32ac3b17};
            seed_val = '0;
            held = '{default: '0};
            fail_cnt = 0;
            restart();
        endfunction

        function void restart();
            foreach (lane[j])
                lane[j] = seed_val;
            slot = 0;
            msg_bytes = '0;
            in_msg = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int unsigned r);
            return (x << r) | (x >> (32 - r));
        endfunction

        function logic [31:0] fmix32(logic [31:0] h);
            h = h ^ (h >> 16);
            h = h * mm3_pkg::FMIX_C1;
            h = h ^ (h >> 13);
            h = h * mm3_pkg::FMIX_C2;
            h = h ^ (h >> 16);
            return h;
        endfunction

        // per-lane word scramble; second constant is the next lane's first
        function logic [31:0] scramble(int unsigned j, logic [31:0] k);
            logic [31:0] t;
            t = k * scr_c[j];
            t = rotl(t, 15 + j);
            t = t * scr_c[(j + 1) % 4];
            return t;
        endfunction

        function void lane_rounds(logic [31:0] k[4]);
            logic [31:0] h;
            for (int j = 0; j < 4; j++)
            begin
                h = lane[j] ^ scramble(j, k[j]);
                h = rotl(h, 19 - 2 * j);
                h = h + lane[(j + 1) % 4];
                lane[j] = h * 32'd5 + blk_c[j];
            end
        endfunction

        function void set_seed(logic [31:0] v);
            seed_val = v;
            if (!in_msg)
                restart();
        endfunction

        // one accepted input item
        function void note_word(logic [31:0] d, logic [2:0] c, logic l);
            logic [31:0] w;
            logic [31:0] k[4];
            logic [31:0] h1, h2, h3, h4;
            int unsigned n;
            w = d;
            n = (c > 3'd4) ? 4 : c;
            if (!in_msg)
            begin
                foreach (lane[j])
                    lane[j] = seed_val;
                in_msg = 1;
            end
            if (!l)
            begin
                // short count on a non-last word is ignored
                msg_bytes = msg_bytes + 32'd4;
                if (slot == 3)
                begin
                    k = '{held[0], held[1], held[2], w};
                    lane_rounds(k);
                end
                else
                    held[slot] = w;
                slot = (slot + 1) % 4;
                return;
            end
            if (n < 4)
                w = w & ((32'd1 << (8 * n)) - 32'd1);
            msg_bytes = msg_bytes + n;
            for (int j = 0; j < 4; j++)
                k[j] = (j < slot) ? held[j] : 32'd0;
            k[slot] = w;
            if (slot == 3 && n == 4)
                lane_rounds(k);
            else
                foreach (lane[j])
                    lane[j] = lane[j] ^ scramble(j, k[j]);
            h1 = lane[0] ^ msg_bytes;
            h2 = lane[1] ^ msg_bytes;
            h3 = lane[2] ^ msg_bytes;
            h4 = lane[3] ^ msg_bytes;
            h1 = h1 + h2 + h3 + h4;
            h2 = h2 + h1;
            h3 = h3 + h1;
            h4 = h4 + h1;
            h1 = fmix32(h1);
            h2 = fmix32(h2);
            h3 = fmix32(h3);
            h4 = fmix32(h4);
            h1 = h1 + h2 + h3 + h4;
            h2 = h2 + h1;
            hash_q.push_back({h2, h1});
            restart();
        endfunction

        // one accepted result item
        function void check_hash(logic [63:0] got, realtime t);
            logic [63:0] want;
            if (hash_q.size() == 0)
            begin
                $display("%0t: unexpected hash item %h", t, got);
                fail_cnt++;
                return;
            end
            want = hash_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: hash_value expected %h actual %h", t, want, got);
                fail_cnt++;
            end
        endfunction

        function int pending();
            return hash_q.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench for murmur3_x86_128_hash_top: directed and random messages,
// seed phases, random idling on both channels. Depends on hash_sb_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT      = 1000000;  // watchdog, cycles
    localparam int SETTLE_CYC = 64;       // longer than the processing of a last item
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD  = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] hash_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] seed;

    hash_sb_pkg::hash_scoreboard sb;

    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    bit          in_quiet = 0;   // sender offers back to back
    bit          out_quiet = 0;  // receiver always ready
    int          hold_req = 0;   // long receiver hold-off, picked up by the receiver

    murmur3_x86_128_hash_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed       (seed)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Idle length: mostly short, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Word content biased toward the extremes.
    function automatic logic [31:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h0000_0000;
        if (r < 16)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Offer one item and hold it until accepted. Called at a rising edge;
    // returns at the edge of acceptance with in_valid still high, so the
    // caller either offers the next item or drops valid in that same step.
    task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l);
        int gap;
        gap = (!in_quiet && $urandom_range(0, 1) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= d;
        byte_count <= c;
        last       <= l;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(d, c, l);
        items_sent++;
    endtask

    // Drop valid, let every expected hash come back, then let the block settle
    // (an item that gives no result may still be in its block round).
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_valid <= 1'b1;
        seed      <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_seed(v);
    endtask

    // n_full words ahead of the last one. Non-last words mostly carry a full
    // count; a few carry a stray random count, which the block must ignore.
    task automatic send_message(input int n_full);
        logic [2:0] c;
        for (int i = 0; i < n_full; i++)
        begin
            c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word(rand_word(), c, 1'b0);
        end
        c = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        send_word(rand_word(), c, 1'b1);
    endtask

    function automatic int msg_words();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 65)
            return $urandom_range(1, 7);
        if (r < 92)
            return $urandom_range(8, 16);
        return $urandom_range(17, 40);
    endfunction

    // Receiver: checks each accepted hash item and drives out_ready.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_hash(hash_value, $realtime);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_quiet)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Sender and sequencing.
    initial
    begin
        logic [31:0] phase_seed[PHASES];
        int unsigned phase_start;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_word  = '0;
        byte_count = '0;
        last       = 1'b0;
        cfg_valid  = 1'b0;
        seed       = '0;
        sb = new();
        phase_seed = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h8000_0000,
                       32'h0000_0001, $urandom, $urandom, 32'hffff_ffff};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset seed of zero.
        // empty message: last with count 0, data bits all masked
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        // single last words (partial and full), and a saturating count
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        // last word completes a full block: block round, empty tail
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        // held words followed by an empty last word
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        // one block round, then a two-byte tail
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        // short count on a non-last word counts as four bytes
        send_word(32'hffff_ffff, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        // seed changed mid-message: lanes keep their values
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        wait_idle();
        write_seed(32'h5a5a_a5a5);
        send_word($urandom, 3'd3, 1'b1);

        // Random part: one seed per phase, block idle before each write.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_seed(phase_seed[p]);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            if (p == 2)
            begin
                // long receiver hold-off while the sender keeps pushing,
                // so the finished hash backs up into the input side
                in_quiet  = 1;
                out_quiet = 0;
                hold_req  = LONG_HOLD;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_message(msg_words());
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (sb.fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
